### sv/central_difference_derivative_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the central difference derivative block
// Concurrent assertion wrappers that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef CENTRAL_DIFFERENCE_DERIVATIVE_ASSERT_SVH
`define CENTRAL_DIFFERENCE_DERIVATIVE_ASSERT_SVH

`ifndef ASSERT_OFF
// Clocked assertion that is switched off while reset is applied.
`define CDD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that is checked during reset as well.
`define CDD_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CDD_ASSERT(label, clk, rst_n, prop, msg)
`define CDD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### sv/cdd_pkg.sv
// ----------------------------------------------------------------------------
// Central difference derivative package
// Widths, register indexes, stencil coefficients and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package cdd_pkg;

	localparam int SAMPLE_W       = 32;
	localparam int OUT_W          = 32;
	localparam int MAX_HALF_WIDTH = 4;
	localparam int WINDOW_DEPTH   = 2 * MAX_HALF_WIDTH + 1;
	localparam int TAP_IDX_W      = $clog2(WINDOW_DEPTH);
	localparam int HW_W           = $clog2(MAX_HALF_WIDTH + 1);
	localparam int SEEN_W         = 4;
	localparam int ORDER_W        = 4;
	localparam int GAIN_W         = 32;
	localparam int GAIN_FRAC      = 16;
	localparam int CFG_INDEX_W    = 1;
	localparam int CFG_DATA_W     = 32;

	// Arithmetic widths of the stencil datapath.
	localparam int DIFF_W      = SAMPLE_W + 1;
	localparam int COEF_W      = 24;
	localparam int FRAC_BITS   = 22;
	localparam int PROD_W      = DIFF_W + COEF_W;
	localparam int ACC_W       = PROD_W + $clog2(MAX_HALF_WIDTH);
	localparam int LO_W        = 29;
	localparam int HI_W        = ACC_W - LO_W;
	localparam int PL_W        = LO_W + GAIN_W;
	localparam int PH_W        = HI_W + GAIN_W + 1;
	localparam int FULL_W      = PH_W + LO_W;
	localparam int ROUND_SHIFT = FRAC_BITS + GAIN_FRAC;

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_W-1:0] CFG_STENCIL_ORDER   = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] CFG_INVERSE_SPACING = CFG_INDEX_W'(1);

	localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(2);
	localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(65536);

	localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1 << FRAC_BITS);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       line_end;
	} sample_item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] derivative;
		logic                    last_result;
		logic                    short_line_error;
	} result_item_t;

	typedef logic [WINDOW_DEPTH-1:0][SAMPLE_W-1:0] window_t;

	typedef struct packed {
		logic valid;
		logic last_result;
		logic short_line_error;
	} stage_ctl_t;

	// One stencil position as handed from the sequencer to the datapath.
	typedef struct packed {
		stage_ctl_t                               ctl;
		logic [MAX_HALF_WIDTH-1:0][DIFF_W-1:0]    diff;
		logic [MAX_HALF_WIDTH-1:0][COEF_W-1:0]    coef;
	} tap_bundle_t;

	typedef struct packed {
		logic              busy;
		logic              issue;
		logic              issue_last;
		logic [SEEN_W-1:0] seen;
	} seq_status_t;

	// Central stencil weights in Q2.22, rounded to nearest, for half-width p and tap k.
	function automatic logic signed [COEF_W-1:0] stencil_coef(
		input logic [HW_W-1:0] p,
		input logic [HW_W-1:0] k
	);
		logic signed [COEF_W-1:0] c;
		c = '0;
		case (p)
			HW_W'(1): begin
				case (k)
					HW_W'(1): c = COEF_W'(2097152);
					default:  c = '0;
				endcase
			end
			HW_W'(2): begin
				case (k)
					HW_W'(1): c = COEF_W'(2796203);
					HW_W'(2): c = COEF_W'(-349525);
					default:  c = '0;
				endcase
			end
			HW_W'(3): begin
				case (k)
					HW_W'(1): c = COEF_W'(3145728);
					HW_W'(2): c = COEF_W'(-629146);
					HW_W'(3): c = COEF_W'(69905);
					default:  c = '0;
				endcase
			end
			HW_W'(4): begin
				case (k)
					HW_W'(1): c = COEF_W'(3355443);
					HW_W'(2): c = COEF_W'(-838861);
					HW_W'(3): c = COEF_W'(159783);
					HW_W'(4): c = COEF_W'(-14980);
					default:  c = '0;
				endcase
			end
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

### sv/cdd_cell.sv
// ----------------------------------------------------------------------------
// Window cell
// Holds one sample of the window and takes its neighbor's sample on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module cdd_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         shift_en,
	input  logic [cdd_pkg::SAMPLE_W-1:0] din,
	output logic [cdd_pkg::SAMPLE_W-1:0] dout
);

	logic [cdd_pkg::SAMPLE_W-1:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
		end else if (shift_en) begin
			value_q <= din;
		end
	end

	assign dout = value_q;

endmodule

`default_nettype wire

### sv/cdd_seq.sv
// ----------------------------------------------------------------------------
// Stencil sequencer
// Accepts samples, tracks the line position and issues one stencil position
// per cycle while the pipeline advances, selecting tap differences and weights from the window cells.
// ----------------------------------------------------------------------------
`default_nettype none

module cdd_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        sample_valid,
	input  logic                        line_end,
	output logic                        sample_stall,
	output logic                        shift_en,
	input  logic [cdd_pkg::ORDER_W-1:0] stencil_order,
	input  logic                        adv,
	input  cdd_pkg::window_t            window,
	output cdd_pkg::tap_bundle_t        bundle_s1,
	output cdd_pkg::seq_status_t        status
);

	logic                        busy_q;
	logic                        flush_q;
	logic                        short_q;
	logic [cdd_pkg::HW_W-1:0]    t_q;
	logic [cdd_pkg::HW_W-1:0]    h_q;
	logic [cdd_pkg::SEEN_W-1:0]  seen_q;
	logic [cdd_pkg::SEEN_W-1:0]  job_seen_q;

	logic [cdd_pkg::HW_W-1:0]    h;
	logic [cdd_pkg::HW_W-1:0]    lag;
	logic [cdd_pkg::SEEN_W-1:0]  seen_next;
	logic [cdd_pkg::SEEN_W-1:0]  pos_last;
	logic                        issue;
	logic                        issue_last;

	logic [cdd_pkg::SEEN_W-1:0]  pos_i;
	logic [cdd_pkg::HW_W-1:0]    p;
	logic                        forward;
	logic                        backward;
	logic [cdd_pkg::MAX_HALF_WIDTH-1:0][cdd_pkg::DIFF_W-1:0] diff;
	logic [cdd_pkg::MAX_HALF_WIDTH-1:0][cdd_pkg::COEF_W-1:0] coef;

	logic                        valid_s1;
	logic                        last_s1;
	logic                        short_s1;
	logic [cdd_pkg::MAX_HALF_WIDTH-1:0][cdd_pkg::DIFF_W-1:0] diff_s1;
	logic [cdd_pkg::MAX_HALF_WIDTH-1:0][cdd_pkg::COEF_W-1:0] coef_s1;

	// Reads a window cell; indexes past the window read as zero.
	function automatic logic signed [cdd_pkg::SAMPLE_W-1:0] tap_at(
		input cdd_pkg::window_t                w,
		input logic [cdd_pkg::TAP_IDX_W-1:0]   idx
	);
		logic signed [cdd_pkg::SAMPLE_W-1:0] v;
		v = '0;
		for (int n = 0; n < cdd_pkg::WINDOW_DEPTH; n++) begin
			if (idx == cdd_pkg::TAP_IDX_W'(n)) begin
				v = w[n];
			end
		end
		return v;
	endfunction

	always_comb begin
		if (stencil_order[cdd_pkg::ORDER_W-1:1] > cdd_pkg::HW_W'(cdd_pkg::MAX_HALF_WIDTH)) begin
			h = cdd_pkg::HW_W'(cdd_pkg::MAX_HALF_WIDTH);
		end else begin
			h = cdd_pkg::HW_W'(stencil_order[cdd_pkg::ORDER_W-1:1]);
		end
		lag = (h == '0) ? cdd_pkg::HW_W'(1) : h;
		seen_next = (seen_q == '1) ? seen_q : seen_q + 1'b1;
		pos_last  = seen_next - 1'b1;
	end

	assign issue        = busy_q && adv;
	assign issue_last   = !flush_q || (t_q == '0);
	assign sample_stall = busy_q && !(issue && issue_last);
	assign shift_en     = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			seen_q <= '0;
		end else begin
			if (shift_en) begin
				seen_q <= line_end ? '0 : seen_next;
				if (line_end) begin
					busy_q <= 1'b1;
				end else begin
					busy_q <= (pos_last >= cdd_pkg::SEEN_W'(lag));
				end
			end else if (issue && issue_last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			job_seen_q <= seen_next;
			h_q        <= h;
			flush_q    <= line_end;
			short_q    <= line_end && (seen_next == cdd_pkg::SEEN_W'(1));
			if (line_end && (pos_last < cdd_pkg::SEEN_W'(lag))) begin
				t_q <= pos_last[cdd_pkg::HW_W-1:0];
			end else begin
				t_q <= lag;
			end
		end else if (issue && !issue_last) begin
			t_q <= t_q - 1'b1;
		end
	end

	// Position of the output point from the start of the line and the usable half-width.
	always_comb begin
		pos_i    = job_seen_q - 1'b1 - cdd_pkg::SEEN_W'(t_q);
		forward  = (pos_i == '0);
		backward = !forward && (t_q == '0);
		p = h_q;
		if (cdd_pkg::SEEN_W'(p) > pos_i) begin
			p = pos_i[cdd_pkg::HW_W-1:0];
		end
		if (p > t_q) begin
			p = t_q;
		end
	end

	always_comb begin
		logic [cdd_pkg::TAP_IDX_W-1:0]     a_idx;
		logic [cdd_pkg::TAP_IDX_W-1:0]     b_idx;
		logic signed [cdd_pkg::SAMPLE_W-1:0] a_val;
		logic signed [cdd_pkg::SAMPLE_W-1:0] b_val;
		for (int k = 0; k < cdd_pkg::MAX_HALF_WIDTH; k++) begin
			a_idx = cdd_pkg::TAP_IDX_W'(t_q) - cdd_pkg::TAP_IDX_W'(k + 1);
			b_idx = cdd_pkg::TAP_IDX_W'(t_q) + cdd_pkg::TAP_IDX_W'(k + 1);
			if (k == 0 && forward) begin
				b_idx = cdd_pkg::TAP_IDX_W'(t_q);
			end else if (k == 0 && backward) begin
				a_idx = cdd_pkg::TAP_IDX_W'(0);
				b_idx = cdd_pkg::TAP_IDX_W'(1);
			end
			a_val = tap_at(window, a_idx);
			b_val = tap_at(window, b_idx);
			diff[k] = {a_val[cdd_pkg::SAMPLE_W-1], a_val} - {b_val[cdd_pkg::SAMPLE_W-1], b_val};
			if (short_q) begin
				coef[k] = '0;
			end else if (forward || backward) begin
				coef[k] = (k == 0) ? cdd_pkg::COEF_ONE : '0;
			end else if (cdd_pkg::HW_W'(k + 1) <= p) begin
				coef[k] = cdd_pkg::stencil_coef(p, cdd_pkg::HW_W'(k + 1));
			end else begin
				coef[k] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1  <= flush_q && (t_q == '0);
			short_s1 <= short_q;
			diff_s1  <= diff;
			coef_s1  <= coef;
		end
	end

	assign bundle_s1.ctl.valid            = valid_s1;
	assign bundle_s1.ctl.last_result      = last_s1;
	assign bundle_s1.ctl.short_line_error = short_s1;
	assign bundle_s1.diff                 = diff_s1;
	assign bundle_s1.coef                 = coef_s1;

	assign status.busy       = busy_q;
	assign status.issue      = issue;
	assign status.issue_last = issue_last;
	assign status.seen       = seen_q;

endmodule

`default_nettype wire

### sv/cdd_arith.sv
// ----------------------------------------------------------------------------
// Stencil datapath
// Weights the tap differences, sums them, applies the spacing gain in two
// partial products, rounds and saturates into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cdd_arith (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic [cdd_pkg::GAIN_W-1:0] gain,
	input  cdd_pkg::tap_bundle_t       bundle_s1,
	output logic                       result_valid,
	output cdd_pkg::result_item_t      result_item
);

	localparam logic signed [cdd_pkg::FULL_W-1:0] ROUND_BIAS =
		{{(cdd_pkg::FULL_W - cdd_pkg::ROUND_SHIFT){1'b0}}, 1'b1,
		 {(cdd_pkg::ROUND_SHIFT - 1){1'b0}}};

	logic signed [cdd_pkg::PROD_W-1:0] prod_s2 [cdd_pkg::MAX_HALF_WIDTH];
	logic signed [cdd_pkg::ACC_W-1:0]  acc_s3;
	logic        [cdd_pkg::PL_W-1:0]   pl_s4;
	logic signed [cdd_pkg::PH_W-1:0]   ph_s4;
	logic signed [cdd_pkg::FULL_W-1:0] full_s5;
	cdd_pkg::result_item_t             result_q;

	logic valid_s2, valid_s3, valid_s4, valid_s5, valid_q;
	logic last_s2, last_s3, last_s4, last_s5;
	logic short_s2, short_s3, short_s4, short_s5;

	logic signed [cdd_pkg::ACC_W-1:0]  acc_sum;
	logic signed [cdd_pkg::FULL_W-1:0] full_sum;
	logic [cdd_pkg::FULL_W-cdd_pkg::ROUND_SHIFT-cdd_pkg::OUT_W:0] top_bits;
	logic signed [cdd_pkg::OUT_W-1:0]  sat_val;

	always_comb begin
		acc_sum = '0;
		for (int k = 0; k < cdd_pkg::MAX_HALF_WIDTH; k++) begin
			acc_sum = acc_sum + {{(cdd_pkg::ACC_W - cdd_pkg::PROD_W){prod_s2[k][cdd_pkg::PROD_W-1]}},
			                     prod_s2[k]};
		end
	end

	// The high partial product fills the full width once shifted up by LO_W.
	assign full_sum = {ph_s4, {cdd_pkg::LO_W{1'b0}}}
	                + {{(cdd_pkg::FULL_W - cdd_pkg::PL_W){1'b0}}, pl_s4}
	                + ROUND_BIAS;

	// The quotient fits the output when its bits above the output sign all match it.
	always_comb begin
		top_bits = full_s5[cdd_pkg::FULL_W-1:cdd_pkg::ROUND_SHIFT+cdd_pkg::OUT_W-1];
		if ((top_bits == '0) || (top_bits == '1)) begin
			sat_val = full_s5[cdd_pkg::ROUND_SHIFT+cdd_pkg::OUT_W-1:cdd_pkg::ROUND_SHIFT];
		end else if (full_s5[cdd_pkg::FULL_W-1]) begin
			sat_val = {1'b1, {(cdd_pkg::OUT_W - 1){1'b0}}};
		end else begin
			sat_val = {1'b0, {(cdd_pkg::OUT_W - 1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (adv) begin
			valid_s2 <= bundle_s1.ctl.valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_q  <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < cdd_pkg::MAX_HALF_WIDTH; k++) begin
				prod_s2[k] <= $signed(bundle_s1.diff[k]) * $signed(bundle_s1.coef[k]);
			end
			last_s2  <= bundle_s1.ctl.last_result;
			short_s2 <= bundle_s1.ctl.short_line_error;

			acc_s3   <= acc_sum;
			last_s3  <= last_s2;
			short_s3 <= short_s2;

			pl_s4    <= acc_s3[cdd_pkg::LO_W-1:0] * gain;
			ph_s4    <= $signed(acc_s3[cdd_pkg::ACC_W-1:cdd_pkg::LO_W]) * $signed({1'b0, gain});
			last_s4  <= last_s3;
			short_s4 <= short_s3;

			full_s5  <= full_sum;
			last_s5  <= last_s4;
			short_s5 <= short_s4;

			result_q.derivative       <= sat_val;
			result_q.last_result      <= last_s5;
			result_q.short_line_error <= short_s5;
		end
	end

	assign result_valid = valid_q;
	assign result_item  = result_q;

endmodule

`default_nettype wire

### sv/central_difference_derivative.sv
// ----------------------------------------------------------------------------
// Central difference derivative
// Streaming derivative of lines of signed samples with one-sided end points.
// ----------------------------------------------------------------------------
// A sample whose line continues is taken every cycle unless the output is
// stalled and gives at most one result, the derivative lagging the newest
// sample by max(H,1) positions, where H = min(stencil_order/2, 4). After the
// sample that carries line_end the sequencer issues min(N-1, max(H,1)) + 1
// stencil positions, up to five, one per cycle while the output is not
// stalled, to flush the rest of the line. Each issued position passes five
// pipeline registers before the output register. When the output is
// stalled the whole pipeline holds and input transfers pause as soon as
// the sequencer has a position to issue.
// Configuration is to be written only while no transfer is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "central_difference_derivative_assert.svh"

module central_difference_derivative (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             sample_valid,
	output logic                             sample_stall,
	input  cdd_pkg::sample_item_t            sample_item,
	output logic                             result_valid,
	input  logic                             result_stall,
	output cdd_pkg::result_item_t            result_item,
	input  logic                             cfg_write_en,
	input  logic [cdd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [cdd_pkg::CFG_DATA_W-1:0]   cfg_data
);

	// Configuration registers.
	logic [cdd_pkg::ORDER_W-1:0] stencil_order_q;
	logic [cdd_pkg::GAIN_W-1:0]  inverse_spacing_q;

	// The pipeline moves whenever the output register is empty or being taken.
	logic                   adv;
	logic                   shift_en;
	cdd_pkg::window_t       window;
	cdd_pkg::tap_bundle_t   bundle_s1;
	cdd_pkg::seq_status_t   seq_status;

	assign adv = !result_valid || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stencil_order_q   <= cdd_pkg::ORDER_RESET;
			inverse_spacing_q <= cdd_pkg::GAIN_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				cdd_pkg::CFG_STENCIL_ORDER: begin
					stencil_order_q <= cfg_data[cdd_pkg::ORDER_W-1:0];
				end
				cdd_pkg::CFG_INVERSE_SPACING: begin
					inverse_spacing_q <= cfg_data[cdd_pkg::GAIN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// The window is a row of cells, newest sample in cell zero. Every input
	// transfer moves each sample one cell further along. Reset clears it.
	for (genvar n = 0; n < cdd_pkg::WINDOW_DEPTH; n++) begin : g_window
		if (n == 0) begin : g_head
			cdd_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (shift_en),
				.din      (sample_item.sample),
				.dout     (window[n])
			);
		end else begin : g_body
			cdd_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (shift_en),
				.din      (window[n-1]),
				.dout     (window[n])
			);
		end
	end

	// The sequencer decides which positions each transfer produces and
	// gathers their tap differences and weights from the window.
	cdd_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.line_end      (sample_item.line_end),
		.sample_stall  (sample_stall),
		.shift_en      (shift_en),
		.stencil_order (stencil_order_q),
		.adv           (adv),
		.window        (window),
		.bundle_s1     (bundle_s1),
		.status        (seq_status)
	);

	// Multiply, accumulate, gain, round and saturate.
	cdd_arith u_arith (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.gain         (inverse_spacing_q),
		.bundle_s1    (bundle_s1),
		.result_valid (result_valid),
		.result_item  (result_item)
	);

	// The window may only move once the current job has issued its last position.
	`CDD_ASSERT(a_no_shift_midjob, clk, arst_n, shift_en |-> (!seq_status.busy || (seq_status.issue && seq_status.issue_last)), "window shifted while positions were still to be issued")
	// A line end always restarts the position count.
	`CDD_ASSERT(a_line_end_clears, clk, arst_n, (shift_en && sample_item.line_end) |=> (seq_status.seen == '0), "position count not cleared after line end")
	// A single-sample line reports a zero derivative as the last result.
	`CDD_ASSERT(a_short_is_last, clk, arst_n, (result_valid && result_item.short_line_error) |-> (result_item.last_result && (result_item.derivative == '0)), "short line result is not a zero last result")
	// Nothing is offered or pending while reset is applied.
	`CDD_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> (!result_valid && !seq_status.busy), "block active during reset")

endmodule

`default_nettype wire
